FILE: design/gha_pkg.sv
// Shared types and codes for the generational handle allocator.
// No dependencies; imported by the top level.
package gha_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_CHECK   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_e;

endpackage

FILE: design/gha_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the new data. No dependencies.
module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/generational_handle_allocator_top.sv
// Generational handle allocator: slot table, free-index stack, result register.
// Depends on gha_pkg and gha_ram.
//
// Channel | Dir | Contents
// s_axis  | in  | tuser: action; tdata: handle_index, handle_generation
// m_axis  | out | tdata: new_index, new_generation, alive, status
//
// One transaction a cycle sustained while the output does not stall. The memory
// reads are issued as the transaction is taken; the update and result are formed
// in the second stage and then registered, with write-through on both RAMs.
// Reset clears the counters and pipeline valids; the RAMs are not cleared.
// A stalled output holds the second stage, and the input then stalls too.
module generational_handle_allocator_top
  import gha_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned GEN_BITS   = 16,
  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT),
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1),
  localparam int unsigned IN_DW  = ((IDX_W + GEN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((IDX_W + GEN_BITS + 1 + STAT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,  // handle_index, handle_generation, pad
  input  logic [ACT_W-1:0]  s_axis_tuser,  // action
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata   // new_index, new_generation, alive, status, pad
);

  localparam int unsigned SLOT_W = GEN_BITS + 1;     // {alive, generation}
  localparam int unsigned STK_W  = GEN_BITS + IDX_W; // {generation, index}

  // input side
  logic                in_accept;
  logic [IDX_W-1:0]    in_index;
  logic [GEN_BITS-1:0] in_gen;

  // second stage
  logic                s1_valid_q;
  action_e             s1_act_q;
  logic [IDX_W-1:0]    s1_idx_q;
  logic [GEN_BITS-1:0] s1_gen_q;
  logic                s1_go;
  logic                fire;

  // state
  logic [CNT_W-1:0]    siu_q, siu_d;
  logic [CNT_W-1:0]    ft_q, ft_d;
  logic [CNT_W-1:0]    ft_next;

  // memories
  logic                slot_we;
  logic [IDX_W-1:0]    slot_waddr;
  logic [SLOT_W-1:0]   slot_wdata;
  logic [SLOT_W-1:0]   slot_rd;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [STK_W-1:0]    stk_wdata;
  logic [IDX_W-1:0]    stk_raddr;
  logic [STK_W-1:0]    stk_rd;

  // result
  logic                live;
  logic [GEN_BITS-1:0] pop_gen;
  logic [IDX_W-1:0]    res_index;
  logic [GEN_BITS-1:0] res_gen;
  logic                res_alive;
  status_e             res_status;
  logic                upd_slot, upd_push;

  logic                out_valid_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [GEN_BITS-1:0] out_gen_q;
  logic                out_alive_q;
  status_e             out_status_q;

  assign in_index      = s_axis_tdata[IDX_W-1:0];
  assign in_gen        = s_axis_tdata[IDX_W +: GEN_BITS];
  assign s1_go         = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && s1_go;
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign live = (CNT_W'(s1_idx_q) < siu_q) && slot_rd[GEN_BITS]
             && (slot_rd[GEN_BITS-1:0] == s1_gen_q);

  always_comb begin
    pop_gen = GEN_BITS'(stk_rd[IDX_W +: GEN_BITS] + 1'b1);
    if (pop_gen == '0) begin
      pop_gen = GEN_BITS'(1);
    end
  end

  always_comb begin
    res_index  = '0;
    res_gen    = '0;
    res_alive  = 1'b0;
    res_status = ST_DONE;
    siu_d      = siu_q;
    ft_d       = ft_q;
    upd_slot   = 1'b0;
    upd_push   = 1'b0;
    slot_waddr = s1_idx_q;
    slot_wdata = {1'b0, s1_gen_q};
    unique case (s1_act_q)
      ACT_CREATE: begin
        if (ft_q != '0) begin
          // reuse the slot on top of the free stack
          ft_d       = ft_q - 1'b1;
          upd_slot   = 1'b1;
          slot_waddr = stk_rd[IDX_W-1:0];
          slot_wdata = {1'b1, pop_gen};
          res_index  = stk_rd[IDX_W-1:0];
          res_gen    = pop_gen;
        end else if (siu_q < CNT_W'(SLOT_COUNT)) begin
          siu_d      = siu_q + 1'b1;
          upd_slot   = 1'b1;
          slot_waddr = siu_q[IDX_W-1:0];
          slot_wdata = {1'b1, GEN_BITS'(1)};
          res_index  = siu_q[IDX_W-1:0];
          res_gen    = GEN_BITS'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_DESTROY: begin
        if (live) begin
          upd_slot = 1'b1;
          if (ft_q < CNT_W'(SLOT_COUNT)) begin
            upd_push = 1'b1;
            ft_d     = ft_q + 1'b1;
          end
        end else begin
          res_status = ST_STALE;
        end
      end
      ACT_CHECK: begin
        res_alive = live;
      end
      ACT_CLEAR: begin
        siu_d = '0;
        ft_d  = '0;
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  assign slot_we   = fire && upd_slot;
  assign stk_we    = fire && upd_push;
  assign stk_waddr = ft_q[IDX_W-1:0];
  // pushed entries carry the generation so a later pop needs no slot read
  assign stk_wdata = {s1_gen_q, s1_idx_q};

  // stack top as it stands after this edge
  assign ft_next   = fire ? ft_d : ft_q;
  assign stk_raddr = IDX_W'(ft_next - CNT_W'(1));

  gha_ram #(
    .Width (SLOT_W),
    .Depth (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (in_accept),
    .raddr_i (in_index),
    .rdata_o (slot_rd)
  );

  gha_ram #(
    .Width (STK_W),
    .Depth (SLOT_COUNT)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      siu_q       <= '0;
      ft_q        <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        siu_q       <= siu_d;
        ft_q        <= ft_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_act_q <= action_e'(s_axis_tuser);
      s1_idx_q <= in_index;
      s1_gen_q <= in_gen;
    end
    if (fire) begin
      out_index_q  <= res_index;
      out_gen_q    <= res_gen;
      out_alive_q  <= res_alive;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'({out_status_q, out_alive_q, out_gen_q, out_index_q});

  // free entries are always a subset of appended slots
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ft_q <= siu_q)
    else $error("free stack deeper than slots in use");

  a_siu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    siu_q <= CNT_W'(SLOT_COUNT))
    else $error("slots in use beyond table size");

  // a full report is only given with an exhausted table and empty stack
  a_full_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_FULL))
      |-> ((siu_q == CNT_W'(SLOT_COUNT)) && (ft_q == '0)))
    else $error("full status with free capacity");

endmodule
